>>> hw/rtl/cds_pkg.sv
// ----------------------------------------------------------------------------
// cds_pkg
// Shared types, codes and calendar helper functions for the date stepper.
// ----------------------------------------------------------------------------
package cds_pkg;

    localparam int MAX_YEAR      = 9999;
    localparam int CMD_W         = 2;
    localparam int DAY_W         = 5;
    localparam int MONTH_W       = 4;
    localparam int YEAR_W        = 14;
    localparam int STATUS_W      = 2;
    localparam int DIST_W        = 23;
    localparam int DAYS_PER_YEAR = 365;
    localparam int MONTHS        = 12;

    // Divisibility by 25 on a 12-bit value: multiply by the inverse of 25
    // modulo 4096, then a multiple of 25 lands at or below 4095 / 25.
    localparam int INV25_MOD4K = 3113;
    localparam int DIV25_LIMIT = 4095 / 25;
    // Quotient by 25 for values below 4096: x * 1311 >> 15.
    localparam int RECIP25     = 1311;
    localparam int RECIP25_SH  = 15;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD = 2'd0,
        CMD_NEXT = 2'd1,
        CMD_PREV = 2'd2,
        CMD_DIST = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_BEFORE_1 = 2'd2,
        ST_PAST_MAX = 2'd3
    } t_status;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EXEC   = 6'b000010,
        S_BASE   = 6'b000100,
        S_LEAP   = 6'b001000,
        S_MONTH  = 6'b010000,
        S_RESULT = 6'b100000
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic capture;    // latch the input transfer
        logic exec;       // apply load / next / prev, validate candidate
        logic ser_base;   // serial count: year * 365 + day, leap quotients
        logic ser_leap;   // serial count: add leap days of prior years
        logic ser_month;  // serial count: add one month length
        logic save_a;     // keep serial of stored date
        logic finish;     // form absolute difference
        logic sel;        // 0: stored date, 1: candidate date
        logic out_load;   // load the result register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        t_cmd cmd;
        logic cand_valid;
        logic month_done;
    } t_dp_status;

    function automatic logic div25_ok(input logic [11:0] x);
        logic [23:0] prod;
        prod = 24'(x) * 24'(INV25_MOD4K);
        return prod[11:0] <= 12'(DIV25_LIMIT);
    endfunction

    function automatic logic [7:0] div25(input logic [11:0] x);
        logic [22:0] prod;
        prod = 23'(x) * 23'(RECIP25);
        return prod[RECIP25_SH +: 8];
    endfunction

    function automatic logic leap_of(input logic [YEAR_W-1:0] y);
        logic by100;
        logic by400;
        by100 = div25_ok(y[13:2]);
        by400 = (y[3:0] == 4'd0) && div25_ok({2'b00, y[13:4]});
        return (y[1:0] == 2'd0) && (!by100 || by400);
    endfunction

    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
        logic [DAY_W-1:0] n;
        case (m)
            4'd2:                      n = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
            default:                   n = 5'd31;
        endcase
        return n;
    endfunction

endpackage

>>> hw/rtl/cds_ifs.sv
// ----------------------------------------------------------------------------
// cds_ifs
// Valid/ready channel interfaces for date commands and date results.
// ----------------------------------------------------------------------------
interface cds_in_if;
    logic                          valid;
    logic                          ready;
    logic [cds_pkg::CMD_W-1:0]     command;
    logic [cds_pkg::DAY_W-1:0]     in_day;
    logic [cds_pkg::MONTH_W-1:0]   in_month;
    logic [cds_pkg::YEAR_W-1:0]    in_year;

    modport source (output valid, command, in_day, in_month, in_year, input ready);
    modport sink   (input valid, command, in_day, in_month, in_year, output ready);
endinterface

interface cds_out_if;
    logic                          valid;
    logic                          ready;
    logic [cds_pkg::DAY_W-1:0]     cur_day;
    logic [cds_pkg::MONTH_W-1:0]   cur_month;
    logic [cds_pkg::YEAR_W-1:0]    cur_year;
    logic                          is_leap;
    logic [cds_pkg::STATUS_W-1:0]  status;
    logic [cds_pkg::DIST_W-1:0]    distance;

    modport source (output valid, cur_day, cur_month, cur_year, is_leap, status,
                    distance, input ready);
    modport sink   (input valid, cur_day, cur_month, cur_year, is_leap, status,
                    distance, output ready);
endinterface

>>> hw/rtl/calendar_date_stepper_core.sv
// ----------------------------------------------------------------------------
// calendar_date_stepper_core
// Gregorian date register with load, next day, previous day and distance.
// ----------------------------------------------------------------------------
// Holds one Gregorian date, 1 January of year 1 after reset. Each command
// transfer yields exactly one result transfer carrying the stored date after
// the command, its leap flag, a status code and, for a good distance command,
// the absolute day count between the stored and the given date (else zero).
// Load and distance check the given date (year 1..9999, month 1..12, day
// within the month, leap rule applied); a failed check, stepping back from
// 1 Jan of year 1, or stepping past 31 Dec of 9999 leaves the date unchanged
// and is reported in status. One command is worked at a time. Distance
// builds each date's serial day number in one shared accumulator that adds
// one month length per cycle. A new command is taken as soon as the
// sequencer is idle, even while the previous result still waits in the
// output register; it then waits for that register to drain before it
// delivers.
// ----------------------------------------------------------------------------
module calendar_date_stepper_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cds_in_if.sink    i_in_chan,
    cds_out_if.source o_out_chan
);
    import cds_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // sequencer: accept, execute, serial counts, hand off to output register
    cds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_chan.valid),
        .o_in_ready  (i_in_chan.ready),
        .i_out_ready (o_out_chan.ready),
        .o_out_valid (o_out_chan.valid),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    // date state, stepping logic, serial accumulator and result register
    cds_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_command     (i_in_chan.command),
        .i_in_day      (i_in_chan.in_day),
        .i_in_month    (i_in_chan.in_month),
        .i_in_year     (i_in_chan.in_year),
        .i_cmd         (dp_cmd),
        .o_status      (dp_status),
        .o_cur_day     (o_out_chan.cur_day),
        .o_cur_month   (o_out_chan.cur_month),
        .o_cur_year    (o_out_chan.cur_year),
        .o_is_leap     (o_out_chan.is_leap),
        .o_status_code (o_out_chan.status),
        .o_distance    (o_out_chan.distance)
    );

endmodule

>>> hw/rtl/cds_ctrl.sv
// ----------------------------------------------------------------------------
// cds_ctrl
// Sequencer for command execution and the two serial day counts.
// ----------------------------------------------------------------------------
module cds_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    input  cds_pkg::t_dp_status  i_status,
    output cds_pkg::t_dp_cmd     o_cmd
);
    import cds_pkg::*;

    t_state r_state, n_state;
    logic   r_sel, n_sel;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_sel       = r_sel;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.sel   = r_sel;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_status.cmd == CMD_DIST && i_status.cand_valid) begin
                    n_sel   = 1'b0;
                    n_state = S_BASE;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_BASE: begin
                o_cmd.ser_base = 1'b1;
                n_state        = S_LEAP;
            end
            S_LEAP: begin
                o_cmd.ser_leap = 1'b1;
                n_state        = S_MONTH;
            end
            S_MONTH: begin
                if (!i_status.month_done) begin
                    o_cmd.ser_month = 1'b1;
                end else if (!r_sel) begin
                    o_cmd.save_a = 1'b1;
                    n_sel        = 1'b1;
                    n_state      = S_BASE;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_RESULT;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sel       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sel       <= n_sel;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> hw/rtl/cds_dp.sv
// ----------------------------------------------------------------------------
// cds_dp
// Stored date, day stepping, candidate check and serial day accumulator.
// ----------------------------------------------------------------------------
module cds_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [cds_pkg::CMD_W-1:0]     i_command,
    input  logic [cds_pkg::DAY_W-1:0]     i_in_day,
    input  logic [cds_pkg::MONTH_W-1:0]   i_in_month,
    input  logic [cds_pkg::YEAR_W-1:0]    i_in_year,
    input  cds_pkg::t_dp_cmd              i_cmd,
    output cds_pkg::t_dp_status           o_status,
    output logic [cds_pkg::DAY_W-1:0]     o_cur_day,
    output logic [cds_pkg::MONTH_W-1:0]   o_cur_month,
    output logic [cds_pkg::YEAR_W-1:0]    o_cur_year,
    output logic                          o_is_leap,
    output logic [cds_pkg::STATUS_W-1:0]  o_status_code,
    output logic [cds_pkg::DIST_W-1:0]    o_distance
);
    import cds_pkg::*;

    // stored date
    logic [DAY_W-1:0]   r_day;
    logic [MONTH_W-1:0] r_month;
    logic [YEAR_W-1:0]  r_year;

    // captured command
    t_cmd               r_cmd;
    logic [DAY_W-1:0]   r_in_day;
    logic [MONTH_W-1:0] r_in_month;
    logic [YEAR_W-1:0]  r_in_year;

    t_status            r_stat;
    logic [DIST_W-1:0]  r_dist;
    logic [DIST_W-1:0]  r_acc;
    logic [DIST_W-1:0]  r_sa;
    logic [MONTH_W-1:0] r_k;
    logic [7:0]         r_q100;
    logic [7:0]         r_q400;

    logic               cur_leap, cand_leap, cand_valid;
    logic [DAY_W-1:0]   cur_dim;
    logic [YEAR_W:0]    nxt_year_w;
    logic               nxt_wrap_day, nxt_wrap_month;
    logic [MONTH_W-1:0] prv_month;
    logic [YEAR_W-1:0]  prv_year;
    logic               prv_ok;

    logic [YEAR_W-1:0]  ser_year, ser_p;
    logic [MONTH_W-1:0] ser_mlim;
    logic [DAY_W-1:0]   ser_day;
    logic               ser_leap;

    always_comb begin
        cur_leap  = leap_of(r_year);
        cand_leap = leap_of(r_in_year);
        cur_dim   = days_in(r_month, cur_leap);
        cand_valid = (r_in_year != '0) && (r_in_year <= YEAR_W'(MAX_YEAR))
                  && (r_in_month != '0) && (r_in_month <= MONTH_W'(MONTHS))
                  && (r_in_day != '0)
                  && (r_in_day <= days_in(r_in_month, cand_leap));

        nxt_wrap_day   = (r_day >= cur_dim);
        nxt_wrap_month = nxt_wrap_day && (r_month >= MONTH_W'(MONTHS));
        nxt_year_w     = {1'b0, r_year} + (YEAR_W+1)'(nxt_wrap_month);

        // Jan wraps to Dec of the prior year; Dec has 31 days either way
        prv_month = (r_month <= 4'd1) ? MONTH_W'(MONTHS) : r_month - 4'd1;
        prv_year  = (r_month <= 4'd1) ? r_year - 14'd1 : r_year;
        prv_ok    = !((r_day <= 5'd1) && (r_month <= 4'd1) && (r_year <= 14'd1));

        ser_year = i_cmd.sel ? r_in_year  : r_year;
        ser_mlim = i_cmd.sel ? r_in_month : r_month;
        ser_day  = i_cmd.sel ? r_in_day   : r_day;
        ser_leap = i_cmd.sel ? cand_leap  : cur_leap;
        ser_p    = ser_year - 14'd1;
    end

    assign o_status.cmd        = r_cmd;
    assign o_status.cand_valid = cand_valid;
    assign o_status.month_done = (r_k >= ser_mlim);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_day   <= DAY_W'(1);
            r_month <= MONTH_W'(1);
            r_year  <= YEAR_W'(1);
        end else if (i_cmd.exec) begin
            case (r_cmd)
                CMD_LOAD: begin
                    if (cand_valid) begin
                        r_day   <= r_in_day;
                        r_month <= r_in_month;
                        r_year  <= r_in_year;
                    end
                end
                CMD_NEXT: begin
                    if (nxt_year_w <= (YEAR_W+1)'(MAX_YEAR)) begin
                        r_day   <= nxt_wrap_day ? DAY_W'(1) : r_day + 5'd1;
                        r_month <= nxt_wrap_month ? MONTH_W'(1)
                                 : (nxt_wrap_day ? r_month + 4'd1 : r_month);
                        r_year  <= nxt_year_w[YEAR_W-1:0];
                    end
                end
                CMD_PREV: begin
                    if (prv_ok) begin
                        if (r_day <= 5'd1) begin
                            r_day   <= days_in(prv_month, cur_leap);
                            r_month <= prv_month;
                            r_year  <= prv_year;
                        end else begin
                            r_day <= r_day - 5'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd      <= t_cmd'(i_command);
            r_in_day   <= i_in_day;
            r_in_month <= i_in_month;
            r_in_year  <= i_in_year;
        end

        if (i_cmd.exec) begin
            r_dist <= '0;
            case (r_cmd)
                CMD_LOAD: r_stat <= cand_valid ? ST_OK : ST_INVALID;
                CMD_NEXT: r_stat <= (nxt_year_w > (YEAR_W+1)'(MAX_YEAR))
                                    ? ST_PAST_MAX : ST_OK;
                CMD_PREV: r_stat <= prv_ok ? ST_OK : ST_BEFORE_1;
                default:  r_stat <= cand_valid ? ST_OK : ST_INVALID;
            endcase
        end

        // serial = y*365 + d + days before month + leap days of years 1..y-1
        if (i_cmd.ser_base) begin
            r_acc  <= DIST_W'(ser_year) * DIST_W'(DAYS_PER_YEAR) + DIST_W'(ser_day);
            r_q100 <= div25(ser_p[13:2]);
            r_q400 <= div25({2'b00, ser_p[13:4]});
            r_k    <= MONTH_W'(1);
        end
        if (i_cmd.ser_leap) begin
            r_acc <= r_acc + DIST_W'(ser_p[13:2]) - DIST_W'(r_q100) + DIST_W'(r_q400);
        end
        if (i_cmd.ser_month) begin
            r_acc <= r_acc + DIST_W'(days_in(r_k, ser_leap));
            r_k   <= r_k + 4'd1;
        end
        if (i_cmd.save_a) begin
            r_sa <= r_acc;
        end
        if (i_cmd.finish) begin
            r_dist <= (r_sa > r_acc) ? r_sa - r_acc : r_acc - r_sa;
        end

        if (i_cmd.out_load) begin
            o_cur_day     <= r_day;
            o_cur_month   <= r_month;
            o_cur_year    <= r_year;
            o_is_leap     <= cur_leap;
            o_status_code <= r_stat;
            o_distance    <= r_dist;
        end
    end

endmodule

>>> sim/tb_calendar_date_stepper_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_calendar_date_stepper_core
// Self-checking bench for the Gregorian date stepper: directed calendar
// corner cases, then constrained-by-hand random command streams, each result
// checked against a cycle-free calendar predictor.
// ----------------------------------------------------------------------------
module tb_calendar_date_stepper_core;
    import cds_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 11;
    localparam int CYCLE_LIMIT   = 600000;  // far above the slowest legal run
    localparam int LONG_STALL    = 300;     // receiver hold-off, in cycles
    localparam int SETTLE_CYCLES = 64;      // settle time before the verdict

    // One predicted result transfer.
    typedef struct {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic               leap;
        t_status            status;
        logic [DIST_W-1:0]  span;
    } t_date_result;

    logic i_clk;
    logic i_rst_n;

    cds_in_if  cmd_chan ();
    cds_out_if res_chan ();

    calendar_date_stepper_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_chan  (cmd_chan),
        .o_out_chan (res_chan)
    );

    // Predictor copy of the stored date.
    int unsigned  track_day;
    int unsigned  track_month;
    int unsigned  track_year;
    t_date_result pending_results [$];

    int error_count;
    int src_idle_pct;          // chance per item that the sender inserts a gap
    int sink_idle_pct;         // chance per cycle that the receiver drops ready
    int long_stalls_asked;     // bumped by the stimulus, served by the sink

    // Years around the leap rule and the ends of the legal range.
    int unsigned boundary_years [0:15] = '{1, 2, 3, 4, 99, 100, 101, 399, 400, 401,
                                           1600, 1900, 2000, 2100, 9998, 9999};

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Calendar predictor
    // ------------------------------------------------------------------------
    function automatic bit leap_year(int unsigned y);
        return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
    endfunction

    function automatic int unsigned month_days(int unsigned m, int unsigned y);
        case (m)
            2:             return leap_year(y) ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    function automatic bit date_ok(int unsigned d, int unsigned m, int unsigned y);
        if (y < 1 || y > MAX_YEAR || m < 1 || m > MONTHS || d < 1)
            return 1'b0;
        return d <= month_days(m, y);
    endfunction

    // Days since a fixed epoch; only differences matter.
    function automatic int unsigned day_number(int unsigned d, int unsigned m,
                                               int unsigned y);
        int unsigned n;
        int unsigned prior;
        n     = y * DAYS_PER_YEAR + d;
        prior = y - 1;
        for (int unsigned k = 1; k < m; k++)
            n += month_days(k, y);
        return n + prior / 4 - prior / 100 + prior / 400;
    endfunction

    // Applies one command to the tracked date and returns the result it owes.
    function automatic t_date_result step_calendar(t_cmd cmd, int unsigned d,
                                                   int unsigned m, int unsigned y);
        t_date_result r;
        int unsigned  nd;
        int unsigned  nm;
        int unsigned  ny;
        int unsigned  a;
        int unsigned  b;
        r.status = ST_OK;
        r.span   = '0;
        case (cmd)
            CMD_LOAD: begin
                if (date_ok(d, m, y)) begin
                    track_day   = d;
                    track_month = m;
                    track_year  = y;
                end else begin
                    r.status = ST_INVALID;
                end
            end
            CMD_NEXT: begin
                nd = track_day + 1;
                nm = track_month;
                ny = track_year;
                if (nd > month_days(nm, ny)) begin
                    nd = 1;
                    nm++;
                    if (nm > MONTHS) begin
                        nm = 1;
                        ny++;
                    end
                end
                if (ny > MAX_YEAR) begin
                    r.status = ST_PAST_MAX;
                end else begin
                    track_day   = nd;
                    track_month = nm;
                    track_year  = ny;
                end
            end
            CMD_PREV: begin
                if (track_day > 1) begin
                    track_day--;
                end else if (track_month > 1) begin
                    track_month--;
                    track_day = month_days(track_month, track_year);
                end else if (track_year > 1) begin
                    track_year--;
                    track_month = MONTHS;
                    track_day   = 31;
                end else begin
                    r.status = ST_BEFORE_1;
                end
            end
            default: begin
                if (date_ok(d, m, y)) begin
                    a      = day_number(track_day, track_month, track_year);
                    b      = day_number(d, m, y);
                    r.span = (a > b) ? a - b : b - a;
                end else begin
                    r.status = ST_INVALID;
                end
            end
        endcase
        r.day   = track_day;
        r.month = track_month;
        r.year  = track_year;
        r.leap  = leap_year(track_year);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: ready generation and checking
    // ------------------------------------------------------------------------
    // Random ready drops per the current idle percentage; a requested long
    // hold-off is counted down here so the sender keeps pushing meanwhile.
    initial begin : result_sink
        int stall_left;
        int stalls_served;
        stall_left    = 0;
        stalls_served = 0;
        res_chan.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stalls_served != long_stalls_asked) begin
                stalls_served = long_stalls_asked;
                stall_left    = LONG_STALL;
            end
            if (stall_left > 0) begin
                stall_left--;
                res_chan.ready <= 1'b0;
            end else begin
                res_chan.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // Every result transfer is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_date_result want;
        if (i_rst_n && res_chan.valid && res_chan.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result transfer with no command outstanding", $time);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                report_field("cur_day",   want.day,    res_chan.cur_day);
                report_field("cur_month", want.month,  res_chan.cur_month);
                report_field("cur_year",  want.year,   res_chan.cur_year);
                report_field("is_leap",   want.leap,   res_chan.is_leap);
                report_field("status",    want.status, res_chan.status);
                report_field("distance",  want.span,   res_chan.distance);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------------
    // Offers one command, possibly after random idle cycles, and records the
    // predicted result once the transfer happens. valid stays high on exit so
    // commands can follow back to back.
    task automatic send_date_cmd(t_cmd cmd, logic [DAY_W-1:0] d,
                                 logic [MONTH_W-1:0] m, logic [YEAR_W-1:0] y);
        while ($urandom_range(99) < src_idle_pct) begin
            cmd_chan.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_chan.valid    <= 1'b1;
        cmd_chan.command  <= cmd;
        cmd_chan.in_day   <= d;
        cmd_chan.in_month <= m;
        cmd_chan.in_year  <= y;
        do
            @(posedge i_clk);
        while (!(cmd_chan.valid && cmd_chan.ready));
        pending_results.push_back(step_calendar(cmd, d, m, y));
    endtask

    // Next / previous with junk in the unused date fields.
    task automatic send_step(t_cmd cmd);
        send_date_cmd(cmd, DAY_W'($urandom), MONTH_W'($urandom), YEAR_W'($urandom));
    endtask

    task automatic wait_results_drained();
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Valid date biased toward month ends, month starts and boundary years.
    task automatic pick_valid_date(output logic [DAY_W-1:0] d,
                                   output logic [MONTH_W-1:0] m,
                                   output logic [YEAR_W-1:0] y);
        int unsigned yy;
        int unsigned mm;
        int unsigned len;
        int          pick;
        if ($urandom_range(7) == 0) begin
            yy = boundary_years[$urandom_range(15)];
            mm = $urandom_range(1) ? ($urandom_range(1) ? 1 : 12) : $urandom_range(1, 12);
        end else begin
            yy = $urandom_range(1, MAX_YEAR);
            mm = $urandom_range(1, 12);
        end
        len  = month_days(mm, yy);
        pick = $urandom_range(5);
        d = (pick < 2) ? len : (pick == 2) ? 1 : $urandom_range(1, len);
        m = mm;
        y = yy;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset date is 1 Jan year 1: stepping back must be refused.
    task automatic test_reset_state();
        send_step(CMD_PREV);
        send_step(CMD_NEXT);
        send_step(CMD_PREV);
    endtask

    // Load validation: zero fields, out-of-range fields, all-ones fields and
    // February in a century year, a 400-year leap year and a plain leap year.
    task automatic test_load_checks();
        send_date_cmd(CMD_LOAD, 5'd0,  4'd1,  14'd2000);
        send_date_cmd(CMD_LOAD, 5'd1,  4'd0,  14'd2000);
        send_date_cmd(CMD_LOAD, 5'd1,  4'd13, 14'd2000);
        send_date_cmd(CMD_LOAD, 5'd31, 4'd15, 14'd16383);
        send_date_cmd(CMD_LOAD, 5'd1,  4'd1,  14'd0);
        send_date_cmd(CMD_LOAD, 5'd1,  4'd1,  14'(MAX_YEAR + 1));
        send_date_cmd(CMD_LOAD, 5'd29, 4'd2,  14'd1900);   // century, not leap
        send_date_cmd(CMD_LOAD, 5'd29, 4'd2,  14'd2000);   // 400-year leap
        send_date_cmd(CMD_LOAD, 5'd30, 4'd2,  14'd2000);
        send_date_cmd(CMD_LOAD, 5'd31, 4'd4,  14'd2023);
        send_date_cmd(CMD_LOAD, 5'd29, 4'd2,  14'd2024);
        send_date_cmd(CMD_LOAD, 5'd31, 4'd12, 14'(MAX_YEAR));
    endtask

    // Top of the range, year rollover backward and month rollover in both directions.
    task automatic test_calendar_limits();
        send_step(CMD_NEXT);                                // past maximum year
        send_step(CMD_PREV);
        send_date_cmd(CMD_LOAD, 5'd1,  4'd1, 14'd2000);
        send_step(CMD_PREV);                                // back into 1999
        send_date_cmd(CMD_LOAD, 5'd28, 4'd2, 14'd2100);
        send_step(CMD_NEXT);                                // 2100 has no 29 Feb
    endtask

    task automatic test_distance();
        send_date_cmd(CMD_LOAD, 5'd31, 4'd12, 14'(MAX_YEAR));
        send_date_cmd(CMD_DIST, 5'd1,  4'd1,  14'd1);       // widest span
        send_date_cmd(CMD_DIST, 5'd30, 4'd2,  14'd2004);    // bad candidate
    endtask

    // Receiver holds off while commands keep coming: the core takes one ahead
    // of its full output register and then must stall the command channel.
    task automatic test_backpressure();
        logic [DAY_W-1:0]   d;
        logic [MONTH_W-1:0] m;
        logic [YEAR_W-1:0]  y;
        long_stalls_asked++;
        pick_valid_date(d, m, y);
        send_date_cmd(CMD_LOAD, d, m, y);
        repeat (3) begin
            pick_valid_date(d, m, y);
            send_date_cmd(CMD_DIST, d, m, y);
            send_step($urandom_range(1) ? CMD_NEXT : CMD_PREV);
        end
        // Sender goes quiet until everything outstanding has come back.
        cmd_chan.valid <= 1'b0;
        wait_results_drained();
    endtask

    // Mostly well-formed runs: a load then a burst of steps and distances;
    // the rest is raw noise on every field.
    task automatic test_random_traffic(int count);
        int                 sent;
        int                 burst;
        int                 pick;
        logic [DAY_W-1:0]   d;
        logic [MONTH_W-1:0] m;
        logic [YEAR_W-1:0]  y;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 80) begin
                pick_valid_date(d, m, y);
                send_date_cmd(CMD_LOAD, d, m, y);
                sent++;
                burst = $urandom_range(1, 10);
                for (int i = 0; i < burst; i++) begin
                    pick = $urandom_range(9);
                    if (pick < 4) begin
                        send_step(CMD_NEXT);
                    end else if (pick < 8) begin
                        send_step(CMD_PREV);
                    end else if ($urandom_range(4) != 0) begin
                        pick_valid_date(d, m, y);
                        send_date_cmd(CMD_DIST, d, m, y);
                    end else begin
                        send_date_cmd(CMD_DIST, DAY_W'($urandom), MONTH_W'($urandom),
                                      YEAR_W'($urandom));
                    end
                    sent++;
                end
            end else begin
                send_date_cmd(t_cmd'($urandom_range(3)), DAY_W'($urandom),
                              MONTH_W'($urandom), YEAR_W'($urandom));
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        error_count       = 0;
        long_stalls_asked = 0;
        src_idle_pct      = 13;
        sink_idle_pct     = 49;
        track_day         = 1;
        track_month       = 1;
        track_year        = 1;

        i_rst_n           <= 1'b0;
        cmd_chan.valid    <= 1'b0;
        cmd_chan.command  <= CMD_LOAD;
        cmd_chan.in_day   <= '0;
        cmd_chan.in_month <= '0;
        cmd_chan.in_year  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_load_checks();
        test_calendar_limits();
        test_distance();
        test_backpressure();

        // Three idle mixes: sender light / receiver heavy, swapped, none.
        test_random_traffic(650);
        src_idle_pct  = 49;
        sink_idle_pct = 13;
        test_random_traffic(650);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_traffic(650);

        cmd_chan.valid <= 1'b0;
        wait_results_drained();
        // Let any stray extra result show up before the verdict.
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/cds_pkg.sv
hw/rtl/cds_ifs.sv
hw/rtl/cds_ctrl.sv
hw/rtl/cds_dp.sv
hw/rtl/calendar_date_stepper_core.sv
sim/tb_calendar_date_stepper_core.sv
